// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the RMS normalization RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RMSN_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rmsn assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define RMSN_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rmsn assertion failed");

`endif

// ===== rtl/core/rmsn_pkg.sv =====
// Package with widths, constants, command and status types for the RMS normalizer.
`timescale 1ns / 1ps
`default_nettype none
package rmsn_pkg;

    // Field and register widths.
    localparam int unsigned DATA_W   = 16;
    localparam int unsigned LEN_W    = 13;
    localparam int unsigned EPS_W    = 25;
    localparam int unsigned SUM_W    = 48;
    localparam int unsigned SCALE_W  = 32;
    localparam int unsigned PROD_W   = 32;
    localparam int unsigned MAG_W    = 63;
    localparam int unsigned DIVQ_W   = 64;
    localparam int unsigned DIVR_W   = 49;
    localparam int unsigned STEP_W   = 6;
    localparam int unsigned CFG_W    = 25;

    // Longest vector supported.
    localparam logic [LEN_W-1:0] MAX_LENGTH = 13'd4096;

    // Reset values of the configuration registers.
    localparam logic [LEN_W-1:0] LEN_RESET = 13'd4096;
    localparam logic [EPS_W-1:0] EPS_RESET = 25'd17;

    localparam logic [SUM_W-1:0]   SUM_MAX   = {SUM_W{1'b1}};
    localparam logic [SCALE_W-1:0] SCALE_MAX = {SCALE_W{1'b1}};

    // Configuration register indexes.
    typedef enum logic [0:0] {
        CFG_VECTOR_LENGTH = 1'b0,
        CFG_EPSILON       = 1'b1
    } t_cfg_index;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic square;
        logic accum;
        logic div_init_len;
        logic div_init_v;
        logic div_step;
        logic scale_max;
        logic sqrt_step;
        logic mul_xw;
        logic mul_scale;
        logic emit;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic scale_ready;
        logic step_last;
        logic sqrt_last;
        logic v_small;
    } t_dp_status;

    // Length as used by the arithmetic: zero counts as one, capped at the maximum.
    function automatic logic [LEN_W-1:0] eff_length(input logic [LEN_W-1:0] len);
        logic [LEN_W-1:0] res;
        res = len;
        if (len == '0) begin
            res = {{(LEN_W-1){1'b0}}, 1'b1};
        end else if (len > MAX_LENGTH) begin
            res = MAX_LENGTH;
        end
        return res;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/rmsn_in_if.sv =====
// Input channel: one sample word with its mode and gain.
`timescale 1ns / 1ps
`default_nettype none
interface rmsn_in_if import rmsn_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic                     mode;
    logic signed [DATA_W-1:0] x_value;
    logic signed [DATA_W-1:0] weight_value;

    modport source (output valid, mode, x_value, weight_value, input ready);
    modport sink   (input valid, mode, x_value, weight_value, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/rmsn_out_if.sv =====
// Output channel: one normalized sample word with its flags.
`timescale 1ns / 1ps
`default_nettype none
interface rmsn_out_if import rmsn_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] y_value;
    logic                     last;
    logic                     saturated;

    modport source (output valid, y_value, last, saturated, input ready);
    modport sink   (input valid, y_value, last, saturated, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/rmsn_dp.sv =====
// Datapath: configuration, running sum, shared divide/square-root unit and output word.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module rmsn_dp import rmsn_pkg::*; (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_cfg_we,
    input  wire logic [0:0]               i_cfg_index,
    input  wire logic [CFG_W-1:0]         i_cfg_data,
    input  wire logic signed [DATA_W-1:0] i_x_value,
    input  wire logic signed [DATA_W-1:0] i_weight_value,
    input  wire t_dp_cmd                  i_cmd,
    output t_dp_status                    o_status,
    output logic signed [DATA_W-1:0]      o_y_value,
    output logic                          o_last,
    output logic                          o_saturated
);

    // Configuration and vector state.
    logic [LEN_W-1:0]   r_vector_length;
    logic [EPS_W-1:0]   r_epsilon;
    logic [SUM_W-1:0]   r_sum;
    logic [LEN_W-1:0]   r_count;
    logic [SCALE_W-1:0] r_scale;
    logic               r_scale_ready;

    // Working registers.
    logic signed [DATA_W-1:0] r_x;
    logic signed [DATA_W-1:0] r_w;
    logic signed [PROD_W-1:0] r_prod;
    logic [MAG_W-1:0]         r_mag;
    logic                     r_neg;
    logic [DIVQ_W-1:0]        r_quo;
    logic [DIVR_W-1:0]        r_rem;
    logic [DIVR_W-1:0]        r_divisor;
    logic [SCALE_W-1:0]       r_root;
    logic [STEP_W-1:0]        r_step;

    // Output word.
    logic signed [DATA_W-1:0] r_y;
    logic                     r_last;
    logic                     r_sat;

    logic [LEN_W-1:0]    len_eff;
    logic [SUM_W:0]      sum_ext;
    logic [DIVR_W-1:0]   v_value;
    logic [DIVR_W:0]     div_rem_s;
    logic [DIVR_W:0]     div_diff;
    logic                div_ge;
    logic                sq_first;
    logic [SCALE_W:0]    sq_rem_cur;
    logic [SCALE_W-1:0]  sq_root_cur;
    logic [SCALE_W+2:0]  sq_rem_s;
    logic [SCALE_W+1:0]  sq_trial;
    logic                sq_ge;
    logic [SCALE_W+2:0]  sq_diff;
    logic [SCALE_W-1:0]  sq_root_new;
    logic [PROD_W-1:0]   prod_abs;
    logic [MAG_W-1:0]    mag_prod;
    logic [MAG_W-1:0]    mag_rnd;
    logic [28:0]         rnd;
    logic                sat_now;
    logic [DATA_W:0]     neg_mag;
    logic [DATA_W:0]     neg_y;
    logic signed [DATA_W-1:0] y_now;
    logic [LEN_W-1:0]    cnt_next;
    logic                last_now;

    assign len_eff = eff_length(r_vector_length);
    assign sum_ext = {1'b0, r_sum} + {{(SUM_W-PROD_W+2){1'b0}}, r_prod[PROD_W-2:0]};
    assign v_value = {1'b0, r_quo[SUM_W-1:0]} + {{(DIVR_W-EPS_W){1'b0}}, r_epsilon};

    // One restoring divide step: remainder picks up the next dividend bit.
    assign div_rem_s = {r_rem, r_quo[DIVQ_W-1]};
    assign div_diff  = div_rem_s - {1'b0, r_divisor};
    assign div_ge    = (div_rem_s >= {1'b0, r_divisor});

    // One square-root step: two radicand bits a step, first step starts from zero.
    assign sq_first    = (r_step == '0);
    assign sq_rem_cur  = sq_first ? '0 : r_rem[SCALE_W:0];
    assign sq_root_cur = sq_first ? '0 : r_root;
    assign sq_rem_s    = {sq_rem_cur, r_quo[DIVQ_W-1 -: 2]};
    assign sq_trial    = {sq_root_cur, 2'b01};
    assign sq_ge       = (sq_rem_s >= {1'b0, sq_trial});
    assign sq_diff     = sq_rem_s - {1'b0, sq_trial};
    assign sq_root_new = {sq_root_cur[SCALE_W-2:0], sq_ge};

    // Magnitude of x*w, at most 2^30.
    assign prod_abs = r_prod[PROD_W-1] ? (~r_prod + 1'b1) : r_prod;

    // Full-width product of the magnitude and the scale.
    assign mag_prod = prod_abs[PROD_W-2:0] * r_scale;

    // Round to nearest, ties away from zero, then clip.
    assign mag_rnd = r_mag + (MAG_W'(1) << 33);
    assign rnd     = mag_rnd[MAG_W-1:34];
    assign neg_mag = (rnd > 29'd32768) ? 17'd32768 : rnd[DATA_W:0];
    assign neg_y   = ~neg_mag + 1'b1;
    always_comb begin
        if (r_neg) begin
            sat_now = (rnd > 29'd32768);
            y_now   = neg_y[DATA_W-1:0];
        end else begin
            sat_now = (rnd > 29'd32767);
            y_now   = sat_now ? 16'sd32767 : rnd[DATA_W-1:0];
        end
    end

    assign cnt_next = r_count + 1'b1;
    assign last_now = (cnt_next >= len_eff);

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vector_length <= LEN_RESET;
            r_epsilon       <= EPS_RESET;
        end else if (i_cfg_we) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_VECTOR_LENGTH: r_vector_length <= i_cfg_data[LEN_W-1:0];
                CFG_EPSILON:       r_epsilon       <= i_cfg_data[EPS_W-1:0];
                default: ;
            endcase
        end
    end

    // Vector state: sum, count and scale.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum         <= '0;
            r_count       <= '0;
            r_scale       <= '0;
            r_scale_ready <= 1'b0;
        end else begin
            if (i_cmd.accum) begin
                r_sum <= sum_ext[SUM_W] ? SUM_MAX : sum_ext[SUM_W-1:0];
            end
            if (i_cmd.scale_max) begin
                r_scale       <= SCALE_MAX;
                r_scale_ready <= 1'b1;
            end
            if (i_cmd.sqrt_step && o_status.sqrt_last) begin
                r_scale       <= sq_root_new;
                r_scale_ready <= 1'b1;
            end
            if (i_cmd.emit) begin
                if (last_now) begin
                    r_sum         <= '0;
                    r_count       <= '0;
                    r_scale       <= '0;
                    r_scale_ready <= 1'b0;
                end else begin
                    r_count <= cnt_next;
                end
            end
        end
    end

    // Sample capture and multipliers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_x <= i_x_value;
            r_w <= i_weight_value;
        end
        if (i_cmd.square) begin
            r_prod <= r_x * r_x;
        end
        if (i_cmd.mul_xw) begin
            r_prod <= r_x * r_w;
        end
        if (i_cmd.mul_scale) begin
            r_mag <= mag_prod;
            r_neg <= r_prod[PROD_W-1];
        end
    end

    // Shared divide / square-root unit.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= '0;
        end else begin
            if (i_cmd.div_init_len || i_cmd.div_init_v) begin
                r_step <= '0;
            end else if (i_cmd.div_step) begin
                r_step <= r_step + 1'b1;
            end else if (i_cmd.sqrt_step) begin
                r_step <= o_status.sqrt_last ? '0 : r_step + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_init_len) begin
            r_quo     <= {{(DIVQ_W-SUM_W){1'b0}}, r_sum};
            r_rem     <= '0;
            r_divisor <= {{(DIVR_W-LEN_W){1'b0}}, len_eff};
        end else if (i_cmd.div_init_v) begin
            // Dividend 2^64: the leading one starts in the remainder.
            r_quo     <= '0;
            r_rem     <= {{(DIVR_W-1){1'b0}}, 1'b1};
            r_divisor <= v_value;
        end else if (i_cmd.div_step) begin
            r_quo <= {r_quo[DIVQ_W-2:0], div_ge};
            r_rem <= div_ge ? div_diff[DIVR_W-1:0] : div_rem_s[DIVR_W-1:0];
        end else if (i_cmd.sqrt_step) begin
            r_quo  <= {r_quo[DIVQ_W-3:0], 2'b00};
            r_rem  <= {{(DIVR_W-SCALE_W-1){1'b0}},
                       sq_ge ? sq_diff[SCALE_W:0] : sq_rem_s[SCALE_W:0]};
            r_root <= sq_root_new;
        end
    end

    // Output word register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_y    <= y_now;
            r_last <= last_now;
            r_sat  <= sat_now;
        end
    end

    assign o_status.scale_ready = r_scale_ready;
    assign o_status.step_last   = (r_step == {STEP_W{1'b1}});
    assign o_status.sqrt_last   = (r_step == STEP_W'(SCALE_W - 1));
    assign o_status.v_small     = (v_value <= DIVR_W'(1));

    assign o_y_value   = r_y;
    assign o_last      = r_last;
    assign o_saturated = r_sat;

    `RMSN_ASSERT_IMP(a_scale_clear, i_clk, i_rst_n, !r_scale_ready, r_scale == '0)
    `RMSN_ASSERT_NXT(a_last_clears, i_clk, i_rst_n, i_cmd.emit && last_now, r_count == '0 && r_sum == '0)

endmodule
`default_nettype wire

// ===== rtl/core/rmsn_ctrl.sv =====
// Controller: sequences accumulate, scale computation and emit, owns the handshakes.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module rmsn_ctrl import rmsn_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    input  wire logic       i_in_mode,
    output logic            o_in_ready,
    input  wire logic       i_out_ready,
    output logic            o_out_valid,
    input  wire t_dp_status i_status,
    output t_dp_cmd         o_cmd
);

    typedef enum logic [9:0] {
        S_IDLE   = 10'b00_0000_0001,
        S_SQUARE = 10'b00_0000_0010,
        S_ACCUM  = 10'b00_0000_0100,
        S_DIVLEN = 10'b00_0000_1000,
        S_EPS    = 10'b00_0001_0000,
        S_DIVV   = 10'b00_0010_0000,
        S_SQRT   = 10'b00_0100_0000,
        S_MULXW  = 10'b00_1000_0000,
        S_MULSC  = 10'b01_0000_0000,
        S_EMIT   = 10'b10_0000_0000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;

    // Next state and datapath commands.
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    if (!i_in_mode) begin
                        n_state = S_SQUARE;
                    end else if (i_status.scale_ready) begin
                        n_state = S_MULXW;
                    end else begin
                        o_cmd.div_init_len = 1'b1;
                        n_state            = S_DIVLEN;
                    end
                end
            end
            S_SQUARE: begin
                o_cmd.square = 1'b1;
                n_state      = S_ACCUM;
            end
            S_ACCUM: begin
                o_cmd.accum = 1'b1;
                n_state     = S_IDLE;
            end
            S_DIVLEN: begin
                o_cmd.div_step = 1'b1;
                if (i_status.step_last) begin
                    n_state = S_EPS;
                end
            end
            S_EPS: begin
                if (i_status.v_small) begin
                    o_cmd.scale_max = 1'b1;
                    n_state         = S_MULXW;
                end else begin
                    o_cmd.div_init_v = 1'b1;
                    n_state          = S_DIVV;
                end
            end
            S_DIVV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.step_last) begin
                    n_state = S_SQRT;
                end
            end
            S_SQRT: begin
                o_cmd.sqrt_step = 1'b1;
                if (i_status.sqrt_last) begin
                    n_state = S_MULXW;
                end
            end
            S_MULXW: begin
                o_cmd.mul_xw = 1'b1;
                n_state      = S_MULSC;
            end
            S_MULSC: begin
                o_cmd.mul_scale = 1'b1;
                n_state         = S_EMIT;
            end
            S_EMIT: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Output word valid: set on emit, cleared when the word is taken.
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.emit) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    `RMSN_ASSERT_NXT(a_emit_sets_valid, i_clk, i_rst_n, o_cmd.emit, o_out_valid)
    `RMSN_ASSERT_NXT(a_sqrt_sets_scale, i_clk, i_rst_n, (r_state == S_SQRT) && i_status.sqrt_last, i_status.scale_ready)
    `RMSN_ASSERT_NXT(a_emit_waits, i_clk, i_rst_n, (r_state == S_EMIT) && r_out_valid && !i_out_ready, r_state == S_EMIT)

endmodule
`default_nettype wire

// ===== rtl/core/rms_normalize_vector.sv =====
// RMS normalization of one vector: top level joining controller and datapath.
// Accumulate word: accepted, squared and added to the sum before the next word is taken.
// Emit word with the scale held: multiplied by its weight, then by the scale; the result word
// is registered in the emit step, which a waiting output word holds, before the next is taken.
// First emit word of a vector first computes the scale: 64-step divide by length,
// epsilon add, 64-step divide into 2^64 and 32-step square root, or a clip after the add.
// Synchronous active-low reset puts control state, sum, count, scale and config at defaults.
`timescale 1ns / 1ps
`default_nettype none
module rms_normalize_vector import rmsn_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_we,
    input  wire logic [0:0]       i_cfg_index,
    input  wire logic [CFG_W-1:0] i_cfg_data,
    rmsn_in_if.sink               i_in,
    rmsn_out_if.source            o_out
);

    t_dp_cmd    cmd;
    t_dp_status status;

    rmsn_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_in_mode   (i_in.mode),
        .o_in_ready  (i_in.ready),
        .i_out_ready (o_out.ready),
        .o_out_valid (o_out.valid),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    rmsn_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_x_value      (i_in.x_value),
        .i_weight_value (i_in.weight_value),
        .i_cmd          (cmd),
        .o_status       (status),
        .o_y_value      (o_out.y_value),
        .o_last         (o_out.last),
        .o_saturated    (o_out.saturated)
    );

endmodule
`default_nettype wire

// ===== dv/rms_normalize_vector_tb.sv =====
// Self-checking testbench for rms_normalize_vector: predicts every normalized word and checks it.
`timescale 1ns / 1ps

import rmsn_pkg::*;

// What one input word asks of the block.
typedef enum logic {
    MODE_SQUARE = 1'b0,
    MODE_EMIT   = 1'b1
} t_word_mode;

// One normalized output word.
typedef struct packed {
    logic signed [DATA_W-1:0] y;
    logic                     last;
    logic                     sat;
} t_norm_word;

// Tracks the vector state, predicts normalized words and checks the output stream.
class norm_scoreboard;
    logic [LEN_W-1:0]   length_reg;
    logic [EPS_W-1:0]   epsilon_reg;
    longint unsigned    sum_sq;
    logic [LEN_W-1:0]   emit_count;
    logic [SCALE_W-1:0] inv_scale;
    bit                 scale_held;
    t_norm_word         pending_words[$];
    int                 errors;
    int                 vectors_done;

    function new();
        length_reg   = LEN_RESET;
        epsilon_reg  = EPS_RESET;
        errors       = 0;
        vectors_done = 0;
        clear_vector();
    endfunction

    function void clear_vector();
        sum_sq     = 0;
        emit_count = '0;
        inv_scale  = '0;
        scale_held = 1'b0;
    endfunction

    // Zero counts as one and anything above the maximum is capped.
    function longint unsigned used_length();
        longint unsigned n;
        n = length_reg;
        if (n == 0) begin
            n = 1;
        end else if (n > MAX_LENGTH) begin
            n = MAX_LENGTH;
        end
        return n;
    endfunction

    function void set_reg(input t_cfg_index idx, input logic [CFG_W-1:0] data);
        case (idx)
            CFG_VECTOR_LENGTH: length_reg = data[LEN_W-1:0];
            CFG_EPSILON:       epsilon_reg = data[EPS_W-1:0];
            default: ;
        endcase
    endfunction

    // Scale in Q0.32: floor(sqrt(floor(2^64 / v))), clipped when v is 0 or 1.
    function logic [SCALE_W-1:0] inverse_root();
        longint unsigned    v;
        longint unsigned    quot;
        longint unsigned    c;
        logic [64:0]        num;
        logic [SCALE_W-1:0] root;
        int                 b;
        v = sum_sq / used_length() + epsilon_reg;
        if (v <= 1) begin
            return SCALE_MAX;
        end
        num  = 65'h1_0000_0000_0000_0000;
        quot = 64'(num / {1'b0, v});
        root = '0;
        for (b = SCALE_W - 1; b >= 0; b--) begin
            c = {32'b0, root | (32'h1 << b)};
            if (c * c <= quot) begin
                root[b] = 1'b1;
            end
        end
        return root;
    endfunction

    // Called for every accepted input word.
    function void note_sample(input t_word_mode mode, input logic signed [DATA_W-1:0] x,
                              input logic signed [DATA_W-1:0] w);
        longint          xw;
        longint unsigned sq;
        longint unsigned mag;
        longint unsigned rnd;
        t_norm_word      res;
        if (mode == MODE_SQUARE) begin
            sq = longint'(x) * longint'(x);
            if (sum_sq > SUM_MAX - sq) begin
                sum_sq = SUM_MAX;
            end else begin
                sum_sq = sum_sq + sq;
            end
            return;
        end
        // The scale is worked out once per vector, on the first emit word.
        if (!scale_held) begin
            inv_scale  = inverse_root();
            scale_held = 1'b1;
        end
        xw  = longint'(x) * longint'(w);
        mag = (xw < 0) ? -xw : xw;
        mag = mag * inv_scale;
        rnd = (mag + (64'd1 << 33)) >> 34;
        res.sat = 1'b0;
        if (xw < 0) begin
            if (rnd > 32768) begin
                rnd     = 32768;
                res.sat = 1'b1;
            end
            res.y = 16'(-rnd);
        end else begin
            if (rnd > 32767) begin
                rnd     = 32767;
                res.sat = 1'b1;
            end
            res.y = 16'(rnd);
        end
        emit_count = emit_count + 1'b1;
        res.last   = (emit_count >= used_length());
        pending_words.push_back(res);
        if (res.last) begin
            clear_vector();
            vectors_done++;
        end
    endfunction

    // Called for every accepted output word.
    function void check_word(input logic signed [DATA_W-1:0] y, input logic last,
                             input logic sat);
        t_norm_word exp_word;
        if (pending_words.size() == 0) begin
            $error("output word with no prediction waiting: y_value %0d", y);
            errors++;
            return;
        end
        exp_word = pending_words.pop_front();
        if (exp_word.y !== y) begin
            $error("y_value mismatch: expected %0d, got %0d", $signed(exp_word.y), y);
            errors++;
        end
        if (exp_word.last !== last) begin
            $error("last mismatch: expected %0b, got %0b", exp_word.last, last);
            errors++;
        end
        if (exp_word.sat !== sat) begin
            $error("saturated mismatch: expected %0b, got %0b", exp_word.sat, sat);
            errors++;
        end
    endfunction

    function int pending();
        return pending_words.size();
    endfunction
endclass

module rms_normalize_vector_tb;
    localparam int SETTLE_CYCLES = 32;
    localparam int HOLD_CYCLES   = 600;
    localparam int RANDOM_ITEMS  = 1400;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_cfg_we;
    logic [0:0]       i_cfg_index;
    logic [CFG_W-1:0] i_cfg_data;

    rmsn_in_if  in_bus ();
    rmsn_out_if out_bus ();

    norm_scoreboard sb;
    bit             steady;
    bit             hold_request;
    int             items_sent;

    rms_normalize_vector uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in        (in_bus),
        .o_out       (out_bus)
    );

    // 100 MHz clock.
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Idle length: mostly none or short, now and then long; none in steady stretches.
    function automatic int pick_gap();
        int r;
        if (steady) begin
            return 0;
        end
        r = $urandom_range(99);
        if (r < 60) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Sample value with extra weight on the extremes and zero.
    function automatic logic [DATA_W-1:0] rand_sample(input bit small_x);
        int r;
        r = $urandom_range(99);
        if (r < 5) return 16'h8000;
        if (r < 10) return 16'h7FFF;
        if (r < 13) return 16'h0000;
        if (small_x) return 16'($urandom_range(511) - 256);
        return 16'($urandom);
    endfunction

    // Offer one word after a random gap and wait for it to be taken.
    task automatic send_word(input t_word_mode mode, input logic [DATA_W-1:0] x,
                             input logic [DATA_W-1:0] w);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_bus.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_bus.valid        <= 1'b1;
        in_bus.mode         <= mode;
        in_bus.x_value      <= x;
        in_bus.weight_value <= w;
        do @(posedge i_clk); while (!in_bus.ready);
        sb.note_sample(mode, x, w);
        items_sent++;
    endtask

    task automatic wait_results();
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    // Let the block go idle, then write both registers on consecutive cycles.
    task automatic reconfigure(input logic [LEN_W-1:0] len, input logic [EPS_W-1:0] eps);
        in_bus.valid <= 1'b0;
        wait_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_VECTOR_LENGTH;
        i_cfg_data  <= {(CFG_W - LEN_W)'($urandom), len};
        @(posedge i_clk);
        sb.set_reg(CFG_VECTOR_LENGTH, i_cfg_data);
        i_cfg_index <= CFG_EPSILON;
        i_cfg_data  <= eps;
        @(posedge i_clk);
        sb.set_reg(CFG_EPSILON, i_cfg_data);
        i_cfg_we <= 1'b0;
    endtask

    // One vector: a square pass then an emit pass until the block closes the vector.
    // Very long vectors are left open and get closed by a later length change.
    task automatic send_vector(input bit pause_midway);
        int len;
        int n_acc;
        int start;
        int emitted;
        bit small_x;
        len = int'(sb.used_length());
        n_acc = ($urandom_range(99) < 80) ? len : $urandom_range(2 * len);
        if (len > 100 && n_acc > 40) begin
            n_acc = $urandom_range(40);
        end
        small_x = ($urandom_range(99) < 20);
        repeat (n_acc) send_word(MODE_SQUARE, rand_sample(small_x), 16'($urandom));
        start   = sb.vectors_done;
        emitted = 0;
        while (sb.vectors_done == start && (len <= 100 || emitted < 30)) begin
            // A stray square word in the emit pass still adds to the sum.
            if ($urandom_range(99) < 5) begin
                send_word(MODE_SQUARE, rand_sample(small_x), 16'($urandom));
            end else begin
                send_word(MODE_EMIT, rand_sample(small_x), 16'($urandom));
                emitted++;
            end
            if (pause_midway && emitted == 1) begin
                in_bus.valid <= 1'b0;
                wait_results();
                pause_midway = 1'b0;
            end
        end
    endtask

    // Output side: random stalls, plus one long hold-off on request.
    initial begin : result_receiver
        int stall;
        out_bus.ready <= 1'b0;
        repeat (8) @(posedge i_clk);
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                stall = HOLD_CYCLES;
            end else begin
                stall = pick_gap();
            end
            if (stall > 0) begin
                out_bus.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_bus.ready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
    end

    // Check every word the block hands over.
    always @(posedge i_clk) begin
        if (i_rst_n && out_bus.valid && out_bus.ready) begin
            sb.check_word(out_bus.y_value, out_bus.last, out_bus.saturated);
        end
    end

    initial begin : stimulus
        int               phase;
        int               n_vec;
        int               base;
        int               r;
        logic [LEN_W-1:0] len;
        logic [EPS_W-1:0] eps;
        sb           = new();
        steady       = 1'b0;
        hold_request = 1'b0;
        items_sent   = 0;
        i_rst_n             <= 1'b0;
        i_cfg_we            <= 1'b0;
        i_cfg_index         <= CFG_VECTOR_LENGTH;
        i_cfg_data          <= '0;
        in_bus.valid        <= 1'b0;
        in_bus.mode         <= MODE_SQUARE;
        in_bus.x_value      <= '0;
        in_bus.weight_value <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Empty sum with zero epsilon: the scale clips to its maximum.
        reconfigure(13'd1, 25'd0);
        send_word(MODE_EMIT, 16'h0000, 16'h0000);

        // Length zero behaves as one; epsilon one still clips the scale.
        reconfigure(13'd0, 25'd1);
        send_word(MODE_EMIT, 16'h7FFF, 16'h7FFF);
        send_word(MODE_EMIT, 16'h8000, 16'h7FFF);
        send_word(MODE_EMIT, 16'h8000, 16'h8000);
        send_word(MODE_EMIT, 16'h0001, 16'h0001);

        // Epsilon 2^24, with a square word slipped into the emit pass.
        reconfigure(13'd3, 25'd16777216);
        send_word(MODE_SQUARE, 16'h8000, 16'h1234);
        send_word(MODE_SQUARE, 16'h7FFF, 16'h8000);
        send_word(MODE_SQUARE, 16'h0000, 16'h7FFF);
        send_word(MODE_EMIT, 16'h1000, 16'h4000);
        send_word(MODE_SQUARE, 16'h8000, 16'hFFFF);
        send_word(MODE_EMIT, 16'hF000, 16'hC000);
        send_word(MODE_EMIT, 16'h7FFF, 16'h8000);

        // Length above the maximum, then lowered below the count mid-pass.
        reconfigure(13'h1FFF, 25'd17);
        send_word(MODE_SQUARE, 16'h8000, 16'($urandom));
        send_word(MODE_SQUARE, 16'h8000, 16'($urandom));
        repeat (3) send_word(MODE_EMIT, 16'($urandom), 16'($urandom));
        reconfigure(13'd2, 25'd17);
        send_word(MODE_EMIT, 16'($urandom), 16'($urandom));

        // Longest vector, closed early by dropping the length to one.
        reconfigure(13'd4096, 25'd17);
        send_word(MODE_SQUARE, 16'h0001, 16'h0000);
        send_word(MODE_EMIT, 16'h0001, 16'h4000);
        reconfigure(13'd1, 25'd5000);
        send_word(MODE_EMIT, 16'($urandom), 16'($urandom));

        // Random phases, each with its own register setting.
        phase = 0;
        base  = items_sent;
        while (items_sent - base < RANDOM_ITEMS) begin
            r = $urandom_range(99);
            if (r < 50) len = 13'($urandom_range(1, 8));
            else if (r < 75) len = 13'($urandom_range(9, 32));
            else if (r < 83) len = 13'($urandom_range(33, 100));
            else if (r < 87) len = 13'd0;
            else if (r < 91) len = 13'd4096;
            else if (r < 95) len = 13'($urandom_range(4097, 8191));
            else len = 13'($urandom_range(101, 4095));
            r = $urandom_range(99);
            if (r < 10) eps = 25'd0;
            else if (r < 20) eps = 25'd16777216;
            else if (r < 30) eps = 25'd1;
            else if (r < 40) eps = 25'd17;
            else if (r < 70) eps = 25'($urandom_range(4095));
            else eps = 25'($urandom_range(16777216));
            reconfigure(len, eps);
            steady = ($urandom_range(99) < 15);
            // Stall the output for a long stretch while words keep coming.
            if (phase == 1) begin
                steady       = 1'b1;
                hold_request = 1'b1;
            end
            n_vec = $urandom_range(2, 6);
            for (int v = 0; v < n_vec; v++) begin
                send_vector(phase == 2 && v == 0);
            end
            phase++;
        end

        // Close any open vector, then a one-word full-scale vector and a last random word.
        reconfigure(13'd1, 25'd0);
        steady = 1'b0;
        send_word(MODE_EMIT, 16'($urandom), 16'($urandom));
        send_word(MODE_SQUARE, 16'h8000, 16'($urandom));
        send_word(MODE_EMIT, 16'h7FFF, 16'h7FFF);
        send_word(MODE_EMIT, 16'($urandom), 16'($urandom));

        in_bus.valid <= 1'b0;
        wait_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // Watchdog well beyond the slowest correct run.
    initial begin : watchdog
        #100_000_000;
        $display("TEST FAILED");
        $finish;
    end
endmodule
